[hw/rtl/owos_pkg.sv]
// Shared types and constants for the word window overlap score unit.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package owos_pkg;

  // Operation carried by the kind field of an input transfer.
  typedef enum logic [1:0] {
    KIND_USER_WORD   = 2'd0,
    KIND_SOURCE_WORD = 2'd1,
    KIND_COMPUTE     = 2'd2,
    KIND_CLEAR_ALL   = 2'd3
  } kind_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ULOAD = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  localparam int unsigned KIND_BITS     = 2;
  localparam int unsigned CODE_BITS     = 32;
  localparam int unsigned CFG_BITS      = 4;
  localparam int unsigned SCORE_BITS    = 7;
  localparam int unsigned COUNT_BITS    = 11;
  localparam int unsigned PCT_SCALE     = 100;
  localparam int unsigned WINDOW_RESET  = 3;

endpackage

[hw/rtl/owos_div.sv]
// Multi-cycle restoring divider producing the 7-bit percentage quotient.
// Depends on owos_pkg for the quotient width.
module owos_div #(
  parameter int unsigned DEN_BITS = 11
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [DEN_BITS+owos_pkg::SCORE_BITS-1:0]      num,
  input  logic [DEN_BITS-1:0]                           den,
  output logic                                          done,
  output logic [owos_pkg::SCORE_BITS-1:0]               quo
);

  localparam int unsigned NUM_BITS = DEN_BITS + owos_pkg::SCORE_BITS;
  localparam int unsigned CNT_BITS = $clog2(owos_pkg::SCORE_BITS);

  logic                busy;
  logic [NUM_BITS-1:0] rem;
  logic [NUM_BITS-1:0] den_shift;
  logic [DEN_BITS-1:0] den_r;
  logic [CNT_BITS-1:0] cnt;

  // The numerator is below 128 times the divisor, so seven quotient bits suffice.
  assign den_shift = NUM_BITS'(den_r) << cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      cnt   <= CNT_BITS'(owos_pkg::SCORE_BITS - 1);
      quo   <= '0;
    end else if (busy) begin
      if (rem >= den_shift) begin
        rem      <= rem - den_shift;
        quo[cnt] <= 1'b1;
      end
      cnt <= cnt - 1'b1;
    end
  end

endmodule

[hw/rtl/word_window_overlap_score_unit.sv]
// Top level of the word window overlap score unit.
// Depends on owos_pkg and owos_div.
//
// The unit keeps a user word list and a source word list in two synchronous
// memories and scores how many user windows of window_size consecutive words
// occur anywhere in the source list. Append and clear transfers are accepted
// back to back. A compute transfer then occupies the unit: for every user
// window it reads the window's w words from the user memory through its one
// read port, then streams the source memory one word a cycle through a
// w-deep compare line until a match is seen or the list ends, and finally
// runs a seven-step divider for the percentage. The compute time is set by
// the single read port of each memory. The finished result sits in an output
// register, so new loads are taken while it waits to be collected. Memory
// entries are never read before they are written, so no clearing pass
// follows reset.
module word_window_overlap_score_unit #(
  parameter int unsigned MAX_USER_WORDS   = 1024,
  parameter int unsigned MAX_SOURCE_WORDS = 1024,
  parameter int unsigned WORD_BITS        = 32,
  parameter int unsigned MAX_WINDOW       = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [owos_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [owos_pkg::KIND_BITS-1:0]        kind,
  input  logic [owos_pkg::CODE_BITS-1:0]        word_code,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [owos_pkg::SCORE_BITS-1:0]       score,
  output logic [owos_pkg::COUNT_BITS-1:0]       matched_windows,
  output logic [owos_pkg::COUNT_BITS-1:0]       total_windows,
  output logic                                  overflow
);

  localparam int unsigned UCW = $clog2(MAX_USER_WORDS + 1);
  localparam int unsigned SCW = $clog2(MAX_SOURCE_WORDS + 1);
  localparam int unsigned UAW = $clog2(MAX_USER_WORDS);
  localparam int unsigned SAW = $clog2(MAX_SOURCE_WORDS);
  localparam int unsigned WW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned NW  = UCW + owos_pkg::SCORE_BITS;

  owos_pkg::state_t state;

  logic [owos_pkg::CFG_BITS-1:0] window_size;
  logic [UCW-1:0]       ucount;
  logic [SCW-1:0]       scount;
  logic                 dropped;

  logic [WW-1:0]        w_eff;
  logic [WW-1:0]        w_cur;
  logic [UCW-1:0]       total;
  logic [UCW-1:0]       total_calc;
  logic [UCW-1:0]       win_idx;
  logic [UCW-1:0]       matched;
  logic [WW-1:0]        k_cnt;
  logic [SCW-1:0]       j_cnt;
  logic [WW-1:0]        filled;
  logic                 div_started;

  logic [WORD_BITS-1:0] user_mem [MAX_USER_WORDS];
  logic [WORD_BITS-1:0] src_mem  [MAX_SOURCE_WORDS];
  logic [WORD_BITS-1:0] u_rdata;
  logic [WORD_BITS-1:0] s_rdata;
  logic [UAW-1:0]       u_raddr;
  logic [SAW-1:0]       s_raddr;
  logic                 u_rd_valid;
  logic                 s_rd_valid;

  logic [WORD_BITS-1:0] usr_win [MAX_WINDOW];
  logic [WORD_BITS-1:0] src_win [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] lane_eq;
  logic                 hit;
  logic                 s_issue;
  logic                 scan_end;

  logic [WORD_BITS-1:0] code_in;
  logic                 in_fire;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  logic [NW-1:0]        div_num;
  logic [owos_pkg::SCORE_BITS-1:0] div_quo;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == owos_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Only the low WORD_BITS bits of a code are kept.
  assign code_in = WORD_BITS'({{(WORD_BITS > owos_pkg::CODE_BITS ?
                    WORD_BITS - owos_pkg::CODE_BITS : 1){1'b0}}, word_code});

  // A window size of zero behaves as one, and sizes past MAX_WINDOW clamp.
  always_comb begin
    if (window_size == '0) begin
      w_eff = WW'(1);
    end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(window_size);
    end
  end

  assign total_calc = (ucount >= UCW'(w_eff)) ? UCW'(ucount - UCW'(w_eff) + 1'b1) : '0;

  // Both compare lines hold their newest word in lane zero, so lane m of each
  // holds the word m places before the window's end and the lanes line up.
  always_comb begin
    for (int m = 0; m < MAX_WINDOW; m++) begin
      lane_eq[m] = (32'(m) >= 32'(w_cur)) || (usr_win[m] == src_win[m]);
    end
  end

  assign hit      = (filled == w_cur) && (&lane_eq);
  assign s_issue  = (j_cnt != scount);
  assign scan_end = hit || (!s_issue && !s_rd_valid);

  assign u_raddr = UAW'(win_idx + UCW'(k_cnt));
  assign s_raddr = SAW'(j_cnt);

  // Memories: one write port driven by loads, one registered read port.
  always_ff @(posedge clk) begin
    if (in_fire && kind == owos_pkg::KIND_USER_WORD && ucount < UCW'(MAX_USER_WORDS)) begin
      user_mem[UAW'(ucount)] <= code_in;
    end
    u_rdata <= user_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && kind == owos_pkg::KIND_SOURCE_WORD &&
        scount < SCW'(MAX_SOURCE_WORDS)) begin
      src_mem[SAW'(scount)] <= code_in;
    end
    s_rdata <= src_mem[s_raddr];
  end

  // Compare lines shift as read data returns.
  always_ff @(posedge clk) begin
    if (u_rd_valid) begin
      usr_win[0] <= u_rdata;
      for (int m = 1; m < MAX_WINDOW; m++) begin
        usr_win[m] <= usr_win[m-1];
      end
    end
    if (s_rd_valid) begin
      src_win[0] <= s_rdata;
      for (int m = 1; m < MAX_WINDOW; m++) begin
        src_win[m] <= src_win[m-1];
      end
    end
  end

  assign div_start = (state == owos_pkg::ST_DIV) && !div_started;
  assign div_num   = NW'(matched) * NW'(owos_pkg::PCT_SCALE);

  owos_div #(
    .DEN_BITS (UCW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (total),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= owos_pkg::ST_IDLE;
      window_size <= owos_pkg::CFG_BITS'(owos_pkg::WINDOW_RESET);
      ucount      <= '0;
      scount      <= '0;
      dropped     <= 1'b0;
      out_valid   <= 1'b0;
      u_rd_valid  <= 1'b0;
      s_rd_valid  <= 1'b0;
      div_started <= 1'b0;
      filled      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
      // A finished result enters the output register once it is free.
      if (state == owos_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      u_rd_valid <= (state == owos_pkg::ST_ULOAD);
      s_rd_valid <= (state == owos_pkg::ST_SCAN) && s_issue && !scan_end;

      if (state != owos_pkg::ST_SCAN) begin
        filled <= '0;
      end else if (s_rd_valid && filled != w_cur) begin
        filled <= filled + 1'b1;
      end

      unique case (state)
        owos_pkg::ST_IDLE: begin
          if (in_fire) begin
            unique case (owos_pkg::kind_t'(kind))
              owos_pkg::KIND_USER_WORD: begin
                if (ucount < UCW'(MAX_USER_WORDS)) begin
                  ucount <= ucount + 1'b1;
                end else begin
                  dropped <= 1'b1;
                end
              end
              owos_pkg::KIND_SOURCE_WORD: begin
                if (scount < SCW'(MAX_SOURCE_WORDS)) begin
                  scount <= scount + 1'b1;
                end else begin
                  dropped <= 1'b1;
                end
              end
              owos_pkg::KIND_COMPUTE: begin
                state <= (total_calc == '0) ? owos_pkg::ST_DONE : owos_pkg::ST_ULOAD;
              end
              owos_pkg::KIND_CLEAR_ALL: begin
                ucount  <= '0;
                scount  <= '0;
                dropped <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        owos_pkg::ST_ULOAD: begin
          if (k_cnt == w_cur - 1'b1) begin
            state <= owos_pkg::ST_SCAN;
          end
        end
        owos_pkg::ST_SCAN: begin
          if (scan_end) begin
            if (win_idx == total - 1'b1) begin
              state <= owos_pkg::ST_DIV;
            end else begin
              state <= owos_pkg::ST_ULOAD;
            end
          end
        end
        owos_pkg::ST_DIV: begin
          div_started <= !div_done;
          if (div_done) begin
            state <= owos_pkg::ST_DONE;
          end
        end
        owos_pkg::ST_DONE: begin
          if (out_free) begin
            scount <= '0;
            state  <= owos_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= owos_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the compute walk and the result register.
  always_ff @(posedge clk) begin
    unique case (state)
      owos_pkg::ST_IDLE: begin
        w_cur   <= w_eff;
        total   <= total_calc;
        win_idx <= '0;
        matched <= '0;
        k_cnt   <= '0;
      end
      owos_pkg::ST_ULOAD: begin
        k_cnt <= k_cnt + 1'b1;
        j_cnt <= '0;
      end
      owos_pkg::ST_SCAN: begin
        if (s_issue) begin
          j_cnt <= j_cnt + 1'b1;
        end
        if (scan_end) begin
          if (hit) begin
            matched <= matched + 1'b1;
          end
          win_idx <= win_idx + 1'b1;
          k_cnt   <= '0;
        end
      end
      owos_pkg::ST_DONE: begin
        if (out_free) begin
          score           <= (total == '0) ? '0 : div_quo;
          matched_windows <= owos_pkg::COUNT_BITS'(matched);
          total_windows   <= owos_pkg::COUNT_BITS'(total);
          overflow        <= dropped;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/owos_chk.sv]
// Port-level checks for the word window overlap score unit, bound to the top.
// Depends on owos_pkg and word_window_overlap_score_unit.
module owos_chk (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [owos_pkg::SCORE_BITS-1:0]       score,
  input logic [owos_pkg::COUNT_BITS-1:0]       matched_windows,
  input logic [owos_pkg::COUNT_BITS-1:0]       total_windows
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(score) && $stable(matched_windows))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> score <= owos_pkg::SCORE_BITS'(owos_pkg::PCT_SCALE))
    else $error("score above full scale");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> matched_windows <= total_windows)
    else $error("more matches than windows");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_windows == '0 |-> score == '0)
    else $error("nonzero score without windows");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind word_window_overlap_score_unit owos_chk u_owos_chk (.*);

[dv/word_window_overlap_score_unit_tb.sv]
// Testbench for the word window overlap score unit.
// Depends on owos_pkg and the RTL top level; it predicts every score itself.
`timescale 1ns / 100ps

module word_window_overlap_score_unit_tb;

  localparam int unsigned USER_CAP  = 1024;
  localparam int unsigned SRC_CAP   = 1024;
  localparam int unsigned WIN_CAP   = 8;
  localparam int unsigned CYCLE_CAP = 1000000;
  // Quiet cycles allowed after the last result before a register write.
  localparam int unsigned SETTLE    = 20;

  typedef struct packed {
    logic [owos_pkg::SCORE_BITS-1:0] pct;
    logic [owos_pkg::COUNT_BITS-1:0] matched;
    logic [owos_pkg::COUNT_BITS-1:0] total;
    logic                            dropped;
  } score_rec_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [owos_pkg::CFG_BITS-1:0]   cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [owos_pkg::KIND_BITS-1:0]  kind = '0;
  logic [owos_pkg::CODE_BITS-1:0]  word_code = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [owos_pkg::SCORE_BITS-1:0] score;
  logic [owos_pkg::COUNT_BITS-1:0] matched_windows;
  logic [owos_pkg::COUNT_BITS-1:0] total_windows;
  logic                            overflow;

  word_window_overlap_score_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .word_code       (word_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .score           (score),
    .matched_windows (matched_windows),
    .total_windows   (total_windows),
    .overflow        (overflow)
  );

  // Shadow copy of the unit's lists, flag and window register.
  logic [owos_pkg::CODE_BITS-1:0] user_words[$];
  logic [owos_pkg::CODE_BITS-1:0] src_words[$];
  logic                           words_dropped;
  logic [owos_pkg::CFG_BITS-1:0]  window_reg;

  // Scores still owed by the unit, oldest first.
  score_rec_t pending_scores[$];

  int  errors    = 0;
  int  cycles    = 0;
  int  sent      = 0;
  bit  idle_on   = 1'b1;
  bit  hold_go   = 1'b0;
  bit  hold_busy = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // A runaway run is cut off here and counts as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // Scores the user windows against the current source list, the way the
  // unit does on a compute transfer, then empties the source list.
  function automatic score_rec_t window_score();
    score_rec_t r;
    int w;
    int tot;
    int hits;
    bit same;
    bit found;
    w = (window_reg == 0) ? 1 : ((window_reg > WIN_CAP) ? WIN_CAP : window_reg);
    tot = (user_words.size() >= w) ? user_words.size() - w + 1 : 0;
    hits = 0;
    for (int i = 0; i < tot; i++) begin
      found = 1'b0;
      for (int j = 0; j + w <= src_words.size() && !found; j++) begin
        same = 1'b1;
        for (int k = 0; k < w; k++) begin
          if (user_words[i + k] != src_words[j + k]) same = 1'b0;
        end
        found = same;
      end
      if (found) hits++;
    end
    r.pct     = (tot == 0) ? '0 :
                owos_pkg::SCORE_BITS'((hits * owos_pkg::PCT_SCALE) / tot);
    r.matched = owos_pkg::COUNT_BITS'(hits);
    r.total   = owos_pkg::COUNT_BITS'(tot);
    r.dropped = words_dropped;
    src_words.delete();
    return r;
  endfunction

  function automatic void apply_item(owos_pkg::kind_t k,
                                     logic [owos_pkg::CODE_BITS-1:0] c);
    case (k)
      owos_pkg::KIND_USER_WORD: begin
        if (user_words.size() < USER_CAP) user_words.insert(user_words.size(), c);
        else words_dropped = 1'b1;
      end
      owos_pkg::KIND_SOURCE_WORD: begin
        if (src_words.size() < SRC_CAP) src_words.insert(src_words.size(), c);
        else words_dropped = 1'b1;
      end
      owos_pkg::KIND_COMPUTE: pending_scores.insert(pending_scores.size(), window_score());
      default: begin
        user_words.delete();
        src_words.delete();
        words_dropped = 1'b0;
      end
    endcase
  endfunction

  // Offers one transfer and waits for its acceptance. Valid stays high
  // between back-to-back transfers and drops only for an idle burst or a drain.
  task automatic send_item(input owos_pkg::kind_t k,
                           input logic [owos_pkg::CODE_BITS-1:0] c);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    word_code <= c;
    do @(posedge clk); while (!in_ready);
    apply_item(k, c);
    sent++;
  endtask

  // Waits until every owed score has come back, plus a few quiet cycles.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [owos_pkg::CFG_BITS-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    window_reg = v;
  endtask

  // Mostly a small alphabet so windows repeat, sometimes any 32-bit code.
  function automatic logic [owos_pkg::CODE_BITS-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return $urandom();
      2: return {$urandom_range(0, 1) ? 28'hfffffff : 28'h0, 4'($urandom_range(0, 3))};
      default: return owos_pkg::CODE_BITS'($urandom_range(0, 4));
    endcase
  endfunction

  // Receiver: random stall bursts, plus one long hold requested by a test.
  initial begin
    int burst;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_busy) begin
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // The long hold is counted in its own process.
  initial begin
    wait (hold_go);
    hold_busy = 1'b1;
    repeat (600) @(posedge clk);
    hold_busy = 1'b0;
  end

  // Every collected score is checked against the oldest prediction.
  always @(posedge clk) begin
    score_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        report("unexpected score", score, -1);
      end else begin
        want = pending_scores.pop_front();
        if (score !== want.pct) report("score", score, want.pct);
        if (matched_windows !== want.matched)
          report("matched_windows", matched_windows, want.matched);
        if (total_windows !== want.total) report("total_windows", total_windows, want.total);
        if (overflow !== want.dropped) report("overflow", overflow, want.dropped);
      end
    end
  end

  // Empty lists, the reset window, all-ones and all-zeros codes, a full match.
  task automatic test_reset_window();
    send_item(owos_pkg::KIND_COMPUTE, '0);
    send_item(owos_pkg::KIND_USER_WORD, '0);
    send_item(owos_pkg::KIND_USER_WORD, '1);
    send_item(owos_pkg::KIND_USER_WORD, 32'h5);
    send_item(owos_pkg::KIND_COMPUTE, '1);
    send_item(owos_pkg::KIND_SOURCE_WORD, 32'h9);
    send_item(owos_pkg::KIND_SOURCE_WORD, '0);
    send_item(owos_pkg::KIND_SOURCE_WORD, '1);
    send_item(owos_pkg::KIND_SOURCE_WORD, 32'h5);
    send_item(owos_pkg::KIND_COMPUTE, '0);
  endtask

  // Zero acts as one, values above eight act as eight, short lists score 0.
  task automatic test_window_limits();
    write_window('0);
    send_item(owos_pkg::KIND_USER_WORD, 32'h7);
    send_item(owos_pkg::KIND_SOURCE_WORD, 32'h7);
    send_item(owos_pkg::KIND_COMPUTE, '0);
    write_window('1);
    for (int i = 0; i < 4; i++) send_item(owos_pkg::KIND_USER_WORD, 32'h7);
    send_item(owos_pkg::KIND_COMPUTE, '0);
    for (int i = 0; i < 5; i++) send_item(owos_pkg::KIND_USER_WORD, 32'h7);
    for (int i = 0; i < 7; i++) send_item(owos_pkg::KIND_SOURCE_WORD, 32'h7);
    send_item(owos_pkg::KIND_COMPUTE, '0);
    for (int i = 0; i < 8; i++) send_item(owos_pkg::KIND_SOURCE_WORD, 32'h7);
    send_item(owos_pkg::KIND_COMPUTE, '0);
    send_item(owos_pkg::KIND_CLEAR_ALL, '1);
  endtask

  // Both lists overrun; the flag survives compute and falls on clear all.
  task automatic test_full_lists();
    write_window(4'd8);
    for (int i = 0; i <= USER_CAP; i++)
      send_item(owos_pkg::KIND_USER_WORD, owos_pkg::CODE_BITS'(i % 9));
    for (int i = 0; i < 9; i++)
      send_item(owos_pkg::KIND_SOURCE_WORD, owos_pkg::CODE_BITS'(i));
    send_item(owos_pkg::KIND_COMPUTE, '0);
    send_item(owos_pkg::KIND_COMPUTE, '0);
    send_item(owos_pkg::KIND_CLEAR_ALL, '0);
    send_item(owos_pkg::KIND_COMPUTE, '0);
    write_window(4'd3);
    for (int i = 0; i < 3; i++)
      send_item(owos_pkg::KIND_USER_WORD, owos_pkg::CODE_BITS'(i + 1));
    for (int i = 0; i <= SRC_CAP; i++)
      send_item(owos_pkg::KIND_SOURCE_WORD, owos_pkg::CODE_BITS'(i % 5));
    send_item(owos_pkg::KIND_COMPUTE, '0);
    send_item(owos_pkg::KIND_CLEAR_ALL, '0);
    send_item(owos_pkg::KIND_COMPUTE, '0);
  endtask

  // Receiver holds off while computes keep arriving, so the input stalls.
  task automatic test_backpressure();
    write_window(4'd2);
    hold_go = 1'b1;
    for (int n = 0; n < 6; n++) begin
      for (int i = 0; i < 4; i++) send_item(owos_pkg::KIND_USER_WORD, pick_word());
      for (int i = 0; i < 4; i++) send_item(owos_pkg::KIND_SOURCE_WORD, pick_word());
      send_item(owos_pkg::KIND_COMPUTE, '0);
      send_item(owos_pkg::KIND_CLEAR_ALL, '0);
    end
  endtask

  // Well-formed load-then-score sequences with random content, some noise.
  task automatic test_random(input int quota, input logic [owos_pkg::CFG_BITS-1:0] win);
    int stop;
    int nu;
    int ns;
    int at;
    write_window(win);
    stop = sent + quota;
    while (sent < stop) begin
      if (user_words.size() > 16 || $urandom_range(0, 2) == 0)
        send_item(owos_pkg::KIND_CLEAR_ALL, $urandom());
      nu = $urandom_range(0, 8);
      for (int i = 0; i < nu; i++) send_item(owos_pkg::KIND_USER_WORD, pick_word());
      ns = $urandom_range(0, 12);
      for (int i = 0; i < ns; i++) begin
        // Copying from the user list makes real window matches likely.
        if (user_words.size() != 0 && $urandom_range(0, 2) != 0) begin
          at = $urandom_range(0, user_words.size() - 1);
          send_item(owos_pkg::KIND_SOURCE_WORD, user_words[at]);
        end else begin
          send_item(owos_pkg::KIND_SOURCE_WORD, pick_word());
        end
      end
      send_item(owos_pkg::KIND_COMPUTE, $urandom());
      if ($urandom_range(0, 7) == 0) send_item(owos_pkg::KIND_COMPUTE, $urandom());
    end
  endtask

  initial begin
    window_reg    = owos_pkg::CFG_BITS'(owos_pkg::WINDOW_RESET);
    words_dropped = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_window_limits();
    test_full_lists();
    test_backpressure();
    test_random(200, 4'd1);
    test_random(200, 4'd3);
    test_random(150, 4'd5);
    test_random(100, 4'd15);
    idle_on = 1'b0;
    test_random(150, 4'd2);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
